FILE: hdl/assert_macros.svh
// assertion macros used by the port checker file
// depends on nothing; the default form assumes clk and arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on a given clock, disabled while reset is low
`define ASSERT_CLK(label, clock, rst_n, prop, msg) \
	label: assert property (@(posedge clock) disable iff (!rst_n) prop) else $error(msg);

// same, on the block clock and reset
`define ASSERT_DEF(label, prop, msg) `ASSERT_CLK(label, clk, arst_n, prop, msg)

`endif

FILE: hdl/icoq_pkg.sv
// types and constants of the interval containment / overlap query block
// depends on nothing; used by every module of the block
package icoq_pkg;

	// op codes of an input transaction
	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;
	localparam logic [1:0] OP_NONE   = 2'd3;

	// query_mode register codes
	localparam logic MODE_INDEX = 1'b0;
	localparam logic MODE_COUNT = 1'b1;

	// answer codes
	localparam logic [11:0] ANS_ZERO = 12'd0;
	localparam logic [11:0] ANS_NONE = 12'hfff;
	localparam logic [11:0] ANS_MAX  = 12'd2047;

	// command queue between front and back, depth a power of two
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = 1;
	localparam int Q_CNT_W = 2;

	typedef struct packed {
		logic [1:0]         op;
		logic signed [63:0] interval_start;
		logic signed [63:0] interval_end;
	} req_item_t;

	typedef struct packed {
		logic signed [11:0] answer;
		logic               status;
	} rsp_item_t;

	typedef enum logic [1:0] {
		KIND_CLEAR,
		KIND_APPEND,
		KIND_QUERY,
		KIND_NOP
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic signed [63:0] lo;
		logic signed [63:0] hi;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} q_stat_t;

endpackage

FILE: hdl/icoq_queue.sv
// short command queue that decouples the front from the back
// depends on icoq_pkg
module icoq_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  icoq_pkg::cmd_t    push_cmd,
	input  logic              pop,
	output icoq_pkg::cmd_t    head,
	output icoq_pkg::q_stat_t stat
);

	icoq_pkg::cmd_t                entries_q [icoq_pkg::Q_DEPTH];
	logic [icoq_pkg::Q_PTR_W-1:0]  wr_ptr_q;
	logic [icoq_pkg::Q_PTR_W-1:0]  rd_ptr_q;
	logic [icoq_pkg::Q_CNT_W-1:0]  cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + icoq_pkg::Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + icoq_pkg::Q_PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + icoq_pkg::Q_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - icoq_pkg::Q_CNT_W'(1);
			end
		end
	end

	assign head           = entries_q[rd_ptr_q];
	assign stat.full      = (cnt_q == icoq_pkg::Q_CNT_W'(icoq_pkg::Q_DEPTH));
	assign stat.not_empty = (cnt_q != '0);

endmodule

FILE: hdl/icoq_front.sv
// front end: takes input transactions and classifies them into commands
// depends on icoq_pkg; feeds icoq_queue
module icoq_front (
	input  logic                 req_valid,
	output logic                 req_stall,
	input  icoq_pkg::req_item_t  req_item,
	input  icoq_pkg::q_stat_t    q_stat,
	output logic                 push,
	output icoq_pkg::cmd_t       push_cmd
);

	always_comb begin
		push_cmd.lo = req_item.interval_start;
		push_cmd.hi = req_item.interval_end;
		case (req_item.op)
			icoq_pkg::OP_CLEAR:  push_cmd.kind = icoq_pkg::KIND_CLEAR;
			icoq_pkg::OP_APPEND: push_cmd.kind = icoq_pkg::KIND_APPEND;
			icoq_pkg::OP_QUERY:  push_cmd.kind = icoq_pkg::KIND_QUERY;
			default:             push_cmd.kind = icoq_pkg::KIND_NOP;
		endcase
	end

	assign req_stall = q_stat.full;
	assign push      = req_valid && !q_stat.full;

endmodule

FILE: hdl/icoq_back.sv
// back end: interval table, scan sequencer and result register
// depends on icoq_pkg; drains commands from icoq_queue
module icoq_back #(
	parameter int MAX_INTERVALS = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  icoq_pkg::cmd_t      cmd,
	input  icoq_pkg::q_stat_t   q_stat,
	output logic                pop,
	input  logic                mode,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output icoq_pkg::rsp_item_t rsp_item
);

	localparam int IDX_W = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
	localparam int CNT_W = $clog2(MAX_INTERVALS + 1);

	typedef struct packed {
		logic signed [63:0] lo;
		logic signed [63:0] hi;
	} ref_t;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_SCAN
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    hits_q;
	logic [IDX_W-1:0]    iss_q;
	logic [IDX_W-1:0]    ridx_q;
	logic                rvalid_q;
	logic                mode_q;
	logic signed [63:0]  qry_lo_q;
	logic signed [63:0]  qry_hi_q;
	logic                rsp_valid_q;
	icoq_pkg::rsp_item_t rsp_item_q;

	ref_t                mem_q [MAX_INTERVALS];
	ref_t                rd_q;

	logic                out_free;
	logic                table_full;
	logic                we;
	logic [IDX_W-1:0]    last_idx;
	logic                cmp_en;
	logic                hit;
	logic                finish;
	logic [11:0]         scan_ans;

	function automatic logic [11:0] sat_ans(input logic [31:0] v);
		return (v > 32'(icoq_pkg::ANS_MAX)) ? icoq_pkg::ANS_MAX : v[11:0];
	endfunction

	assign out_free   = !rsp_valid_q || !rsp_stall;
	assign pop        = (state_q == ST_IDLE) && q_stat.not_empty && out_free;
	assign table_full = (count_q == CNT_W'(MAX_INTERVALS));
	assign we         = pop && (cmd.kind == icoq_pkg::KIND_APPEND) && !table_full;
	assign last_idx   = IDX_W'(count_q - CNT_W'(1));
	assign cmp_en     = (state_q == ST_SCAN) && rvalid_q;

	always_comb begin
		if (mode_q == icoq_pkg::MODE_INDEX) begin
			hit = (rd_q.lo <= qry_lo_q) && (qry_hi_q <= rd_q.hi);
		end else begin
			hit = (qry_lo_q <= rd_q.hi) && (rd_q.lo <= qry_hi_q);
		end
	end

	assign finish = cmp_en && (((mode_q == icoq_pkg::MODE_INDEX) && hit) ||
		(ridx_q == last_idx));

	always_comb begin
		if (mode_q == icoq_pkg::MODE_INDEX) begin
			scan_ans = hit ? sat_ans(32'(ridx_q)) : icoq_pkg::ANS_NONE;
		end else begin
			scan_ans = sat_ans(32'(hits_q) + 32'(hit));
		end
	end

	// table write at the fill position, one read port swept by the scan
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[count_q[IDX_W-1:0]] <= ref_t'{lo: cmd.lo, hi: cmd.hi};
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem_q[iss_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			hits_q      <= '0;
			iss_q       <= '0;
			ridx_q      <= '0;
			rvalid_q    <= 1'b0;
			mode_q      <= icoq_pkg::MODE_COUNT;
			qry_lo_q    <= '0;
			qry_hi_q    <= '0;
			rsp_valid_q <= 1'b0;
			rsp_item_q  <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					rvalid_q <= 1'b0;
					if (pop) begin
						rsp_item_q.answer <= icoq_pkg::ANS_ZERO;
						rsp_item_q.status <= 1'b0;
						case (cmd.kind)
							icoq_pkg::KIND_CLEAR: begin
								count_q     <= '0;
								rsp_valid_q <= 1'b1;
							end
							icoq_pkg::KIND_APPEND: begin
								if (table_full) begin
									rsp_item_q.status <= 1'b1;
								end else begin
									count_q <= count_q + CNT_W'(1);
								end
								rsp_valid_q <= 1'b1;
							end
							icoq_pkg::KIND_QUERY: begin
								if (count_q == '0) begin
									// empty table answers at once
									if (mode == icoq_pkg::MODE_INDEX) begin
										rsp_item_q.answer <= icoq_pkg::ANS_NONE;
									end
									rsp_valid_q <= 1'b1;
								end else begin
									mode_q   <= mode;
									qry_lo_q <= cmd.lo;
									qry_hi_q <= cmd.hi;
									hits_q   <= '0;
									iss_q    <= '0;
									state_q  <= ST_SCAN;
								end
							end
							default: begin
								rsp_valid_q <= 1'b1;
							end
						endcase
					end
				end
				ST_SCAN: begin
					// read data comes back in the cycle after its issue index
					ridx_q   <= iss_q;
					rvalid_q <= !finish;
					if (iss_q != last_idx) begin
						iss_q <= iss_q + IDX_W'(1);
					end
					if (cmp_en && hit) begin
						hits_q <= hits_q + CNT_W'(1);
					end
					if (finish) begin
						rsp_item_q.answer <= scan_ans;
						rsp_item_q.status <= 1'b0;
						rsp_valid_q       <= 1'b1;
						state_q           <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_item_q;

endmodule

FILE: hdl/interval_containment_overlap_query.sv
// Interval containment / overlap query block. Holds up to MAX_INTERVALS
// reference intervals in load order and takes one transaction at a time on
// the req channel: clear, append or query. Each transaction returns exactly
// one result on the rsp channel. A clear, an append, an unused op code and a
// query on an empty table may follow back to back while results are taken.
// A query over n stored intervals sweeps the table through its single read
// port, one entry per cycle; in index mode the sweep stops at the first
// containing interval. A two-entry command queue sits between the front
// and the back, and the result register lets the next command start while
// a result is being taken. query_mode is sampled when a query starts.
// depends on icoq_pkg, icoq_front, icoq_queue, icoq_back
module interval_containment_overlap_query #(
	parameter int MAX_INTERVALS = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  icoq_pkg::req_item_t req_item,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output icoq_pkg::rsp_item_t rsp_item,
	input  logic                cfg_we,
	input  logic                cfg_wdata
);

	logic              query_mode_q;
	logic              push;
	logic              pop;
	icoq_pkg::cmd_t    push_cmd;
	icoq_pkg::cmd_t    head;
	icoq_pkg::q_stat_t q_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_mode_q <= icoq_pkg::MODE_COUNT;
		end else if (cfg_we) begin
			query_mode_q <= cfg_wdata;
		end
	end

	icoq_front u_front (
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_item  (req_item),
		.q_stat    (q_stat),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	icoq_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.stat     (q_stat)
	);

	icoq_back #(
		.MAX_INTERVALS (MAX_INTERVALS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.mode      (query_mode_q),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_item  (rsp_item)
	);

endmodule

FILE: hdl/icoq_checker.sv
// port-level checker for the interval query block, bound to the top level
// depends on icoq_pkg and assert_macros.svh
`include "assert_macros.svh"

module icoq_port_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_stall,
	input icoq_pkg::req_item_t req_item,
	input logic                rsp_valid,
	input logic                rsp_stall,
	input icoq_pkg::rsp_item_t rsp_item,
	input logic                cfg_we,
	input logic                cfg_wdata
);

	logic [3:0] pend_q;
	logic       mode_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = req_valid && !req_stall;
	assign out_acc = rsp_valid && !rsp_stall;

	// transactions taken in whose result has not yet been delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			mode_q <= icoq_pkg::MODE_COUNT;
		end else begin
			pend_q <= pend_q + 4'(in_acc) - 4'(out_acc);
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
		end
	end

	`ASSERT_DEF(a_no_orphan_result, rsp_valid |-> (pend_q != 4'd0),
		"result without a pending transaction")
	`ASSERT_DEF(a_drop_has_zero_answer,
		(rsp_valid && rsp_item.status) |-> (rsp_item.answer == 12'sd0),
		"dropped append with non-zero answer")
	`ASSERT_DEF(a_count_not_negative,
		(rsp_valid && (mode_q == icoq_pkg::MODE_COUNT)) |-> !rsp_item.answer[11],
		"negative overlap count")
	`ASSERT_DEF(a_rsp_hold,
		(rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_item)),
		"stalled result changed")

endmodule

bind interval_containment_overlap_query icoq_port_checker u_icoq_checker (.*);
